// File: rtl/core/tlge_pkg.sv
// Shared types and constants for the toroidal Life generation engine.
// Row-wide bank storage: one memory word holds one full grid row.
// No dependencies.
package tlge_pkg;

    // Grid edge length in cells (square, toroidal)
    localparam int GRID_DIM = 256;
    // Row / column index width
    localparam int ROW_W = $clog2(GRID_DIM);
    // Generation read counter: counts up to GRID_DIM + 2
    localparam int CNT_W = $clog2(GRID_DIM + 3);

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // One grid row of cells, bit c is column c
    typedef logic [GRID_DIM-1:0] row_t;

    // Single-port bank access
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] addr;
        row_t             wdata;
    } bank_req_t;

endpackage

// File: rtl/core/toroidal_life_generation_engine_top.sv
// Top level of the toroidal Life generation engine: sequencer and bank routing.
// Depends on tlge_pkg, tlge_bank_ram, tlge_row_rule.
//
//  channel  | handshake              | fields
//  ---------+------------------------+-------------------------------------
//  command  | start in, busy out     | operation, row, col, cell_value
//  result   | result_valid out       | read_value
//
// After reset a clearing pass zeroes bank a, one row a cycle, through all
// GRID_DIM rows; busy stays high meanwhile.
// A read or write first reads the row from the active bank, then the bit is
// picked or the modified row is written back. Out-of-grid items stay in idle.
// A generation reads one row per cycle from the active bank through a
// three-row window and writes one new row per cycle to the other bank.
// Each bank has a single port.
// result_valid pulses for one cycle per read; the receiver cannot stall.
module toroidal_life_generation_engine_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] row,
    input  logic [7:0] col,
    input  logic       cell_value,
    output logic       result_valid,
    output logic       read_value
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_ACC   = 4'b0100,
        ST_GEN   = 4'b1000
    } state_t;

    localparam logic [tlge_pkg::ROW_W-1:0] LAST_ROW = tlge_pkg::ROW_W'(tlge_pkg::GRID_DIM - 1);
    localparam logic [tlge_pkg::CNT_W-1:0] LAST_RD  = tlge_pkg::CNT_W'(tlge_pkg::GRID_DIM + 1);

    // Control state
    state_t                       state_reg, state_next;
    logic                         active_reg, active_next;
    logic [tlge_pkg::ROW_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [tlge_pkg::CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                         rvalid_reg, rvalid_next;
    logic                         wvalid_reg, wvalid_next;
    logic                         result_valid_reg, result_valid_next;

    // Payload
    logic [tlge_pkg::CNT_W-1:0]   rk_reg;
    logic [tlge_pkg::ROW_W-1:0]   waddr_reg;
    logic [tlge_pkg::ROW_W-1:0]   row_reg, col_reg;
    logic                         val_reg, is_write_reg;
    logic                         read_value_reg, read_value_next;
    tlge_pkg::row_t               north_reg, center_reg, south_reg;

    // Bank ports
    tlge_pkg::bank_req_t          act_req, oth_req, a_req, b_req;
    tlge_pkg::row_t               a_rdata, b_rdata, act_rdata;
    tlge_pkg::row_t               mod_row, gen_row;

    logic                         accept, in_grid;
    logic [tlge_pkg::ROW_W-1:0]   in_row, in_col;

    assign accept  = start && !busy;
    assign in_grid = (int'(row) < tlge_pkg::GRID_DIM) && (int'(col) < tlge_pkg::GRID_DIM);
    assign in_row  = tlge_pkg::ROW_W'(row);
    assign in_col  = tlge_pkg::ROW_W'(col);

    // Route active / other ports to the two banks
    assign a_req     = active_reg ? oth_req : act_req;
    assign b_req     = active_reg ? act_req : oth_req;
    assign act_rdata = active_reg ? b_rdata : a_rdata;

    tlge_bank_ram u_bank_a
    (
        .clk   (clk),
        .req   (a_req),
        .rdata (a_rdata)
    );

    tlge_bank_ram u_bank_b
    (
        .clk   (clk),
        .req   (b_req),
        .rdata (b_rdata)
    );

    tlge_row_rule u_rule
    (
        .north    (north_reg),
        .center   (center_reg),
        .south    (south_reg),
        .next_row (gen_row)
    );

    // Row with the addressed cell replaced, for write-back
    always_comb
    begin
        mod_row          = act_rdata;
        mod_row[col_reg] = val_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        clr_cnt_next      = clr_cnt_reg;
        rd_cnt_next       = rd_cnt_reg;
        rvalid_next       = 1'b0;
        wvalid_next       = 1'b0;
        result_valid_next = 1'b0;
        read_value_next   = 1'b0;
        act_req           = '0;
        oth_req           = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                act_req.we   = 1'b1;
                act_req.addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        tlge_pkg::OP_WRITE:
                        begin
                            if (in_grid)
                            begin
                                act_req.addr = in_row;
                                state_next   = ST_ACC;
                            end
                        end
                        tlge_pkg::OP_READ:
                        begin
                            if (in_grid)
                            begin
                                act_req.addr = in_row;
                                state_next   = ST_ACC;
                            end
                            else
                            begin
                                result_valid_next = 1'b1;
                            end
                        end
                        tlge_pkg::OP_STEP:
                        begin
                            rd_cnt_next = '0;
                            state_next  = ST_GEN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ACC:
            begin
                // Row data of the addressed cell is now on act_rdata
                if (is_write_reg)
                begin
                    act_req.we    = 1'b1;
                    act_req.addr  = row_reg;
                    act_req.wdata = mod_row;
                end
                else
                begin
                    result_valid_next = 1'b1;
                    read_value_next   = act_rdata[col_reg];
                end
                state_next = ST_IDLE;
            end

            ST_GEN:
            begin
                // Read order: last row, rows 0..last, row 0 again
                if (rd_cnt_reg <= LAST_RD)
                begin
                    priority if (rd_cnt_reg == '0)
                    begin
                        act_req.addr = LAST_ROW;
                    end
                    else if (rd_cnt_reg == LAST_RD)
                    begin
                        act_req.addr = '0;
                    end
                    else
                    begin
                        act_req.addr = tlge_pkg::ROW_W'(rd_cnt_reg - 1'b1);
                    end
                    rvalid_next = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                // Window full once the third row has arrived
                wvalid_next = rvalid_reg && (rk_reg >= tlge_pkg::CNT_W'(2));
                // Write the new row to the other bank
                if (wvalid_reg)
                begin
                    oth_req.we    = 1'b1;
                    oth_req.addr  = waddr_reg;
                    oth_req.wdata = gen_row;
                    if (waddr_reg == LAST_ROW)
                    begin
                        active_next = !active_reg;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            active_reg       <= 1'b0;
            clr_cnt_reg      <= '0;
            rd_cnt_reg       <= '0;
            rvalid_reg       <= 1'b0;
            wvalid_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_reg       <= active_next;
            clr_cnt_reg      <= clr_cnt_next;
            rd_cnt_reg       <= rd_cnt_next;
            rvalid_reg       <= rvalid_next;
            wvalid_reg       <= wvalid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        rk_reg         <= rd_cnt_reg;
        if (accept)
        begin
            row_reg      <= in_row;
            col_reg      <= in_col;
            val_reg      <= cell_value;
            is_write_reg <= (operation == tlge_pkg::OP_WRITE);
        end
        if (rvalid_reg)
        begin
            north_reg  <= center_reg;
            center_reg <= south_reg;
            south_reg  <= act_rdata;
            waddr_reg  <= tlge_pkg::ROW_W'(rk_reg - tlge_pkg::CNT_W'(2));
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign read_value   = read_value_reg;

    // Generation rows are written in strictly ascending order
    assert property (@(posedge clk) disable iff (!rst_n)
        (wvalid_reg && $past(wvalid_reg)) |->
            (waddr_reg == tlge_pkg::ROW_W'($past(waddr_reg) + 1'b1)))
        else $error("generation row write out of order");

    // The inactive bank is only written during a generation
    assert property (@(posedge clk) disable iff (!rst_n)
        oth_req.we |-> (state_reg == ST_GEN))
        else $error("inactive bank written outside a generation");

    // Banks swap only at the end of a generation
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg != $past(active_reg)) |->
            ($past(state_reg) == ST_GEN && $past(wvalid_reg)))
        else $error("bank swap outside generation end");

    // Cell access phase only follows an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> $past(start && !busy))
        else $error("access phase without accepted item");

    // A result only follows a cell access or a just-accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ($past(state_reg) == ST_ACC || $past(accept)))
        else $error("result without a read");

endmodule

// File: rtl/core/tlge_bank_ram.sv
// One cell bank: GRID_DIM rows of GRID_DIM cells, single port, read-first.
// Read data registered. Uses tlge_pkg.
module tlge_bank_ram
(
    input  logic                clk,
    input  tlge_pkg::bank_req_t req,
    output tlge_pkg::row_t      rdata
);

    tlge_pkg::row_t mem [tlge_pkg::GRID_DIM];
    tlge_pkg::row_t rdata_reg;

    // Write and registered read on the same address
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tlge_row_rule.sv
// B3/S23 rule applied to one full row, with column wrap at both edges.
// Takes the rows above, at and below the target row. Uses tlge_pkg.
module tlge_row_rule
(
    input  tlge_pkg::row_t north,
    input  tlge_pkg::row_t center,
    input  tlge_pkg::row_t south,
    output tlge_pkg::row_t next_row
);

    // One lane per column; neighbor columns wrap around
    for (genvar c = 0; c < tlge_pkg::GRID_DIM; c++)
    begin : g_lane
        localparam int CL = (c + tlge_pkg::GRID_DIM - 1) % tlge_pkg::GRID_DIM;
        localparam int CR = (c + 1) % tlge_pkg::GRID_DIM;

        logic [3:0] nb_count;

        assign nb_count = 4'(north[CL]) + 4'(north[c]) + 4'(north[CR])
                        + 4'(center[CL]) + 4'(center[CR])
                        + 4'(south[CL]) + 4'(south[c]) + 4'(south[CR]);

        // Born on exactly 3, survives on 2 or 3
        assign next_row[c] = (nb_count == 4'd3) || (center[c] && (nb_count == 4'd2));
    end

endmodule
